// ----- hdl/pkt_pkg.sv -----
// pairing key table: shared types, field widths, command and status codes
// used by the channel interfaces and the table module
`timescale 1ns / 1ps

package pkt_pkg;

  localparam int PKT_ENTRIES = 8;

  localparam int CMD_W   = 3;
  localparam int ID_W    = 8;
  localparam int ADDR_W  = 48;
  localparam int KIND_W  = 8;
  localparam int TYPES_W = 16;
  localparam int SLOT_W  = 3;
  localparam int BUSY_W  = 8;
  localparam int STAT_W  = 3;
  localparam int AGE_W   = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_FIND_ADDR  = 3'd0,
    CMD_FIND_TYPE  = 3'd1,
    CMD_GET        = 3'd2,
    CMD_GET_TYPE   = 3'd3,
    CMD_CLEAR_SLOT = 3'd4,
    CMD_ADD_TYPE   = 3'd5,
    CMD_TOUCH      = 3'd6
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_FOUND    = 3'd0,
    ST_CREATED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_DONE     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SLOT,
    S_DECIDE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]    ident;
    logic [ADDR_W-1:0]  addr;
    logic [KIND_W-1:0]  kind;
    logic [TYPES_W-1:0] mask;
    logic [AGE_W-1:0]   age;
  } entry_t;

endpackage

// ----- hdl/pkt_ifs.sv -----
// pairing key table: valid/ready channel interfaces for requests,
// results and the configuration write; depends on pkt_pkg
`timescale 1ns / 1ps

interface pkt_req_if import pkt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [ID_W-1:0]    local_id;
  logic [ADDR_W-1:0]  peer_address;
  logic [KIND_W-1:0]  address_type;
  logic [TYPES_W-1:0] type_bits;
  logic [SLOT_W-1:0]  slot_index;
  logic [BUSY_W-1:0]  busy_mask;

  modport source (output valid, cmd, local_id, peer_address, address_type, type_bits,
                  slot_index, busy_mask, input ready);
  modport sink (input valid, cmd, local_id, peer_address, address_type, type_bits,
                slot_index, busy_mask, output ready);
endinterface

interface pkt_rsp_if import pkt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [SLOT_W-1:0]  result_slot;
  logic [TYPES_W-1:0] result_types;
  logic               was_evicted;

  modport source (output valid, status, result_slot, result_types, was_evicted,
                  input ready);
  modport sink (input valid, status, result_slot, result_types, was_evicted,
                output ready);
endinterface

interface pkt_cfg_if import pkt_pkg::*; ();
  logic valid;
  logic ready;
  logic evict_oldest_enable;

  modport source (output valid, evict_oldest_enable, input ready);
  modport sink (input valid, evict_oldest_enable, output ready);
endinterface

// ----- hdl/pairing_key_table.sv -----
// pairing key table top level: entry memory, scan sequencer and result register
// depends on pkt_pkg and the channel interfaces in pkt_ifs.sv
`timescale 1ns / 1ps
//
// Usage:
//   req carries one command item (lookup, get/allocate, slot clear, slot type add,
//   touch); rsp returns exactly one result item per command; cfg writes the
//   evict_oldest_enable bit and is always ready (write it only while idle).
// Sequencing:
//   lookup, get and touch commands walk all ENTRIES entries through the single
//   read port of the entry memory, one entry per cycle, with the match, free,
//   and oldest-age compares done on the registered read data. The result is
//   decided in S_DECIDE, registered, and offered on rsp in S_OUT.
//   Slot commands read the addressed entry in S_SLOT first; an unknown command
//   goes straight to S_DECIDE. One item is in work at a time: req.ready is high
//   only while idle, so an item holds the block until rsp takes its result.
// Stall:
//   the result stays in its register, stable, until rsp.ready is seen high;
//   the next item is accepted in the cycle after that.
// Reset:
//   all entries read as empty (per-entry valid bits clear at once), the age
//   counter and last touched mark clear, eviction is off. No clearing pass.
//
module pairing_key_table import pkt_pkg::*; #(
  parameter int ENTRIES = PKT_ENTRIES
) (
  input  logic      clk,
  input  logic      rst,
  pkt_req_if.sink   req,
  pkt_rsp_if.source rsp,
  pkt_cfg_if.sink   cfg
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
  localparam logic [CW-1:0] END_IDX  = CW'(ENTRIES);

  state_t state;
  state_t state_next;
  logic   evict_en;

  // latched request
  cmd_t               req_cmd;
  logic [ID_W-1:0]    req_id;
  logic [ADDR_W-1:0]  req_addr;
  logic [KIND_W-1:0]  req_kind;
  logic [TYPES_W-1:0] req_types;
  logic [SLOT_W-1:0]  req_sidx;
  logic [BUSY_W-1:0]  req_busy;

  // entry memory
  entry_t             mem [ENTRIES];
  logic [ENTRIES-1:0] vld;
  entry_t             rd_data;
  logic               rd_vld;
  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  entry_t             wr_data;

  // scan pipeline
  logic [CW-1:0] idx;
  logic          chk_v;
  logic [IW-1:0] chk_idx;

  // scan trackers
  logic               hit_any;
  logic [IW-1:0]      hit_slot;
  entry_t             hit_ent;
  logic               thit_any;
  logic [IW-1:0]      thit_slot;
  logic [TYPES_W-1:0] thit_mask;
  logic               free_any;
  logic [IW-1:0]      free_slot;
  logic [TYPES_W-1:0] free_mask;
  logic               old_any;
  logic [IW-1:0]      old_slot;
  logic [AGE_W-1:0]   old_age;

  logic [AGE_W-1:0] age_ctr;
  logic [AGE_W-1:0] age_next;
  logic [IW-1:0]    lt_slot;
  logic             lt_valid;
  logic             do_stamp;
  logic [IW-1:0]    stamp_slot;

  // result register
  logic [STAT_W-1:0]  out_status;
  logic [SLOT_W-1:0]  out_slot;
  logic [TYPES_W-1:0] out_types;
  logic               out_evicted;
  status_t            o_status;
  logic [IW-1:0]      o_slot;
  logic [TYPES_W-1:0] o_types;
  logic               o_evicted;

  // compare unit on the entry under check
  entry_t             cur;
  logic               same_peer;
  logic               type_hit;
  logic               is_free;
  logic               busy_bit;
  logic               older;
  logic               req_take;
  logic               sidx_ok;
  logic [IW-1:0]      sidx_i;
  logic [TYPES_W-1:0] get_types;

  assign req_take  = (state == S_IDLE) && req.valid;
  assign age_next  = age_ctr + AGE_W'(1);
  assign sidx_ok   = ({29'd0, req_sidx} < 32'(ENTRIES));
  assign sidx_i    = IW'(req_sidx);
  assign get_types = (req_cmd == CMD_GET_TYPE) ? req_types : '0;

  // an entry that was never written reads as all zero
  assign cur       = rd_vld ? rd_data : '0;
  assign same_peer = (cur.ident == req_id) && (cur.addr == req_addr) &&
                     (cur.kind == req_kind);
  assign type_hit  = (cur.mask & req_types) != '0;
  assign is_free   = (cur.addr == '0) && (cur.kind == '0);
  assign busy_bit  = (32'(chk_idx) < 32'd8) && req_busy[3'(chk_idx)];
  assign older     = cur.age < old_age;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign rsp.valid        = (state == S_OUT);
  assign rsp.status       = out_status;
  assign rsp.result_slot  = out_slot;
  assign rsp.result_types = out_types;
  assign rsp.was_evicted  = out_evicted;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_vld  <= vld[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      evict_en <= 1'b0;
      vld      <= '0;
      age_ctr  <= '0;
      lt_slot  <= '0;
      lt_valid <= 1'b0;
      idx      <= '0;
      chk_v    <= 1'b0;
      hit_any  <= 1'b0;
      thit_any <= 1'b0;
      free_any <= 1'b0;
      old_any  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        evict_en <= cfg.evict_oldest_enable;
      end
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (do_stamp) begin
        age_ctr  <= age_next;
        lt_slot  <= stamp_slot;
        lt_valid <= 1'b1;
      end
      if (req_take) begin
        idx      <= '0;
        chk_v    <= 1'b0;
        hit_any  <= 1'b0;
        thit_any <= 1'b0;
        free_any <= 1'b0;
        old_any  <= 1'b0;
      end else if (state == S_SCAN) begin
        if (idx < END_IDX) begin
          idx   <= idx + CW'(1);
          chk_v <= 1'b1;
        end else begin
          chk_v <= 1'b0;
        end
        if (chk_v) begin
          if (same_peer) begin
            hit_any <= 1'b1;
          end
          if (same_peer && type_hit) begin
            thit_any <= 1'b1;
          end
          if (is_free) begin
            free_any <= 1'b1;
          end
          if (!busy_bit) begin
            old_any <= 1'b1;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_take) begin
      req_cmd   <= cmd_t'(req.cmd);
      req_id    <= req.local_id;
      req_addr  <= req.peer_address;
      req_kind  <= req.address_type;
      req_types <= req.type_bits;
      req_sidx  <= req.slot_index;
      req_busy  <= req.busy_mask;
    end
    if (state == S_SCAN) begin
      chk_idx <= idx[IW-1:0];
      if (chk_v) begin
        if (same_peer && !hit_any) begin
          hit_slot <= chk_idx;
          hit_ent  <= cur;
        end
        if (same_peer && type_hit && !thit_any) begin
          thit_slot <= chk_idx;
          thit_mask <= cur.mask;
        end
        if (is_free && !free_any) begin
          free_slot <= chk_idx;
          free_mask <= cur.mask;
        end
        // strict compare keeps the lowest index on equal ages
        if (!busy_bit && (!old_any || older)) begin
          old_slot <= chk_idx;
          old_age  <= cur.age;
        end
      end
    end
    if (state == S_DECIDE) begin
      out_status  <= o_status;
      out_slot    <= SLOT_W'(o_slot);
      out_types   <= o_types;
      out_evicted <= o_evicted;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = idx[IW-1:0];
    wr_en      = 1'b0;
    wr_addr    = hit_slot;
    wr_data    = hit_ent;
    do_stamp   = 1'b0;
    stamp_slot = hit_slot;
    o_status   = ST_NOTFOUND;
    o_slot     = '0;
    o_types    = '0;
    o_evicted  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          unique case (cmd_t'(req.cmd))
            CMD_FIND_ADDR, CMD_FIND_TYPE, CMD_GET, CMD_GET_TYPE, CMD_TOUCH: begin
              state_next = S_SCAN;
            end
            CMD_CLEAR_SLOT, CMD_ADD_TYPE: begin
              state_next = S_SLOT;
            end
            default: begin
              state_next = S_DECIDE;
            end
          endcase
        end
      end
      S_SCAN: begin
        rd_en = (idx < END_IDX);
        if (chk_v && (chk_idx == LAST_IDX)) begin
          state_next = S_DECIDE;
        end
      end
      S_SLOT: begin
        rd_en      = sidx_ok;
        rd_addr    = sidx_i;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = S_OUT;
        unique case (req_cmd)
          CMD_FIND_ADDR: begin
            if (hit_any) begin
              o_status = ST_FOUND;
              o_slot   = hit_slot;
              o_types  = hit_ent.mask;
            end
          end
          CMD_FIND_TYPE: begin
            if (thit_any) begin
              o_status = ST_FOUND;
              o_slot   = thit_slot;
              o_types  = thit_mask;
            end
          end
          CMD_TOUCH: begin
            if (hit_any) begin
              o_status = ST_DONE;
              o_slot   = hit_slot;
              o_types  = hit_ent.mask;
              // touching the entry already marked last leaves the age alone
              if (!(lt_valid && (lt_slot == hit_slot))) begin
                wr_en       = 1'b1;
                wr_data.age = age_next;
                do_stamp    = 1'b1;
              end
            end
          end
          CMD_GET, CMD_GET_TYPE: begin
            priority if ((req_cmd == CMD_GET_TYPE) && thit_any) begin
              o_status = ST_FOUND;
              o_slot   = thit_slot;
              o_types  = thit_mask;
            end else if (hit_any) begin
              o_status     = ST_FOUND;
              o_slot       = hit_slot;
              o_types      = hit_ent.mask | get_types;
              wr_en        = (req_cmd == CMD_GET_TYPE);
              wr_data.mask = hit_ent.mask | get_types;
            end else if (free_any) begin
              o_status   = ST_CREATED;
              o_slot     = free_slot;
              o_types    = free_mask | get_types;
              wr_en      = 1'b1;
              wr_addr    = free_slot;
              wr_data    = '{ident: req_id, addr: req_addr, kind: req_kind,
                             mask: free_mask | get_types, age: age_next};
              do_stamp   = 1'b1;
              stamp_slot = free_slot;
            end else if (evict_en && old_any) begin
              o_status   = ST_CREATED;
              o_slot     = old_slot;
              o_types    = get_types;
              o_evicted  = 1'b1;
              wr_en      = 1'b1;
              wr_addr    = old_slot;
              wr_data    = '{ident: req_id, addr: req_addr, kind: req_kind,
                             mask: get_types, age: age_next};
              do_stamp   = 1'b1;
              stamp_slot = old_slot;
            end else begin
              o_status = ST_FULL;
            end
          end
          CMD_CLEAR_SLOT: begin
            if (sidx_ok) begin
              o_status = ST_DONE;
              o_slot   = sidx_i;
              wr_en    = 1'b1;
              wr_addr  = sidx_i;
              wr_data  = '0;
            end
          end
          CMD_ADD_TYPE: begin
            if (sidx_ok) begin
              o_status     = ST_DONE;
              o_slot       = sidx_i;
              o_types      = cur.mask | req_types;
              wr_en        = 1'b1;
              wr_addr      = sidx_i;
              wr_data      = cur;
              wr_data.mask = cur.mask | req_types;
            end
          end
          default: begin
            o_status = ST_NOTFOUND;
          end
        endcase
      end
      S_OUT: begin
        if (rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- verif/tb_pairing_key_table.sv -----
// testbench for pairing_key_table: drives commands over the request channel,
// predicts every result from its own copy of the table and checks the response channel
// depends on pkt_pkg, the channel interfaces in pkt_ifs.sv and pairing_key_table
`timescale 1ns / 1ps

module tb_pairing_key_table;
  import pkt_pkg::*;

  localparam int LIMIT = 300000;
  localparam int HOLD_AT = 300;
  localparam int HOLD_LEN = 400;
  localparam int NPEERS = 12;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 3'd7;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [ID_W-1:0]    local_id;
    logic [ADDR_W-1:0]  peer_address;
    logic [KIND_W-1:0]  address_type;
    logic [TYPES_W-1:0] type_bits;
    logic [SLOT_W-1:0]  slot_index;
    logic [BUSY_W-1:0]  busy_mask;
    logic               drain;
  } key_cmd_t;

  typedef struct {
    logic [STAT_W-1:0]  status;
    logic [SLOT_W-1:0]  result_slot;
    logic [TYPES_W-1:0] result_types;
    logic               was_evicted;
  } key_answer_t;

  logic clk;
  logic rst;

  pkt_req_if req_ch ();
  pkt_rsp_if rsp_ch ();
  pkt_cfg_if cfg_ch ();

  pairing_key_table u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // local copy of the table
  logic [ID_W-1:0]    tbl_ident [PKT_ENTRIES] = '{default: '0};
  logic [ADDR_W-1:0]  tbl_addr  [PKT_ENTRIES] = '{default: '0};
  logic [KIND_W-1:0]  tbl_kind  [PKT_ENTRIES] = '{default: '0};
  logic [TYPES_W-1:0] tbl_mask  [PKT_ENTRIES] = '{default: '0};
  logic [AGE_W-1:0]   tbl_age   [PKT_ENTRIES] = '{default: '0};
  logic [AGE_W-1:0]   age_ctr = '0;
  logic [SLOT_W-1:0]  last_slot = '0;
  logic               last_valid = 1'b0;
  logic               evict_on = 1'b0;

  key_cmd_t    cmd_q [$];
  key_answer_t answer_q [$];
  key_cmd_t    on_bus;

  logic [ID_W-1:0]   pool_id   [NPEERS];
  logic [ADDR_W-1:0] pool_addr [NPEERS];
  logic [KIND_W-1:0] pool_kind [NPEERS];

  int  n_sent = 0;
  int  n_bad = 0;
  int  cyc = 0;
  int  tx_gap = 0;
  int  rx_gap = 0;
  int  hold_left = 0;
  bit  hold_used = 0;
  bit  tx_idle_on = 1;
  bit  rx_idle_on = 1;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.cmd = '0;
    req_ch.local_id = '0;
    req_ch.peer_address = '0;
    req_ch.address_type = '0;
    req_ch.type_bits = '0;
    req_ch.slot_index = '0;
    req_ch.busy_mask = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.evict_oldest_enable = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int find_entry(key_cmd_t c, bit by_type);
    for (int i = 0; i < PKT_ENTRIES; i++) begin
      if (by_type && (tbl_mask[i] & c.type_bits) == '0) continue;
      if (tbl_ident[i] == c.local_id && tbl_addr[i] == c.peer_address &&
          tbl_kind[i] == c.address_type) return i;
    end
    return -1;
  endfunction

  function automatic void wipe_entry(int i);
    tbl_ident[i] = '0;
    tbl_addr[i] = '0;
    tbl_kind[i] = '0;
    tbl_mask[i] = '0;
    tbl_age[i] = '0;
  endfunction

  function automatic void stamp_entry(int i);
    age_ctr = age_ctr + 1'b1;
    tbl_age[i] = age_ctr;
    last_slot = SLOT_W'(i);
    last_valid = 1'b1;
  endfunction

  // expected result of one command, updating the local table
  function automatic key_answer_t table_answer(key_cmd_t c);
    key_answer_t a;
    int hit;
    int pick;
    bit created;
    bit evicted;
    a.status = ST_NOTFOUND;
    hit = -1;
    pick = -1;
    created = 0;
    evicted = 0;
    case (c.cmd)
      CMD_FIND_ADDR, CMD_FIND_TYPE: begin
        hit = find_entry(c, c.cmd == CMD_FIND_TYPE);
        if (hit >= 0) a.status = ST_FOUND;
      end
      CMD_GET, CMD_GET_TYPE: begin
        if (c.cmd == CMD_GET_TYPE) hit = find_entry(c, 1'b1);
        if (hit >= 0) begin
          a.status = ST_FOUND;
        end else begin
          hit = find_entry(c, 1'b0);
          if (hit < 0) begin
            for (int i = 0; i < PKT_ENTRIES; i++)
              if (pick < 0 && tbl_addr[i] == '0 && tbl_kind[i] == '0) pick = i;
            if (pick < 0 && evict_on) begin
              // oldest entry not held by a live connection, lowest index on ties
              for (int i = 0; i < PKT_ENTRIES; i++) begin
                if (i < BUSY_W && c.busy_mask[i]) continue;
                if (pick < 0 || tbl_age[i] < tbl_age[pick]) pick = i;
              end
              if (pick >= 0) begin
                wipe_entry(pick);
                evicted = 1;
              end
            end
            if (pick >= 0) begin
              tbl_ident[pick] = c.local_id;
              tbl_addr[pick] = c.peer_address;
              tbl_kind[pick] = c.address_type;
              stamp_entry(pick);
              created = 1;
            end
            hit = pick;
          end
          if (hit < 0) begin
            a.status = ST_FULL;
          end else begin
            if (c.cmd == CMD_GET_TYPE) tbl_mask[hit] = tbl_mask[hit] | c.type_bits;
            a.status = created ? ST_CREATED : ST_FOUND;
          end
        end
      end
      CMD_CLEAR_SLOT, CMD_ADD_TYPE: begin
        if (c.slot_index < PKT_ENTRIES) begin
          hit = int'(c.slot_index);
          if (c.cmd == CMD_CLEAR_SLOT) wipe_entry(hit);
          else tbl_mask[hit] = tbl_mask[hit] | c.type_bits;
          a.status = ST_DONE;
        end
      end
      CMD_TOUCH: begin
        hit = find_entry(c, 1'b0);
        if (hit >= 0) begin
          if (!(last_valid && last_slot == SLOT_W'(hit))) stamp_entry(hit);
          a.status = ST_DONE;
        end
      end
      default: ;
    endcase
    a.result_slot = (hit < 0) ? '0 : SLOT_W'(hit);
    a.result_types = (hit < 0) ? '0 : tbl_mask[hit];
    a.was_evicted = evicted;
    return a;
  endfunction

  // request driver
  always @(posedge clk) begin
    key_cmd_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        answer_q.push_back(table_answer(on_bus));
        n_sent++;
      end
      if (req_ch.valid && !req_ch.ready) begin
        // hold the offered item
      end else if (tx_gap != 0) begin
        req_ch.valid <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (cmd_q.size() != 0 && !(cmd_q[0].drain && answer_q.size() != 0)) begin
        nxt = cmd_q.pop_front();
        on_bus <= nxt;
        req_ch.cmd <= nxt.cmd;
        req_ch.local_id <= nxt.local_id;
        req_ch.peer_address <= nxt.peer_address;
        req_ch.address_type <= nxt.address_type;
        req_ch.type_bits <= nxt.type_bits;
        req_ch.slot_index <= nxt.slot_index;
        req_ch.busy_mask <= nxt.busy_mask;
        req_ch.valid <= 1'b1;
        tx_gap <= tx_idle_on ? int'($urandom_range(0, 11)) : 0;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // one long receiver hold-off so the block backs up into the request side
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_used && n_sent >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_used <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    key_answer_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (answer_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("unexpected result: status %0d slot %0d types %h evicted %0b",
                     rsp_ch.status, rsp_ch.result_slot, rsp_ch.result_types,
                     rsp_ch.was_evicted);
        end else begin
          want = answer_q.pop_front();
          if (rsp_ch.status !== want.status || rsp_ch.result_slot !== want.result_slot ||
              rsp_ch.result_types !== want.result_types ||
              rsp_ch.was_evicted !== want.was_evicted) begin
            n_bad++;
            if (n_bad <= 10)
              $display({"mismatch at %0t: exp status %0d slot %0d types %h ev %0b,",
                        " %s %0d %0d %h %0b"},
                       $realtime, want.status, want.result_slot, want.result_types,
                       want.was_evicted, "got", rsp_ch.status, rsp_ch.result_slot,
                       rsp_ch.result_types, rsp_ch.was_evicted);
          end
        end
        rx_gap = rx_idle_on ? int'($urandom_range(0, 11)) : 0;
      end else if (rx_gap != 0) begin
        rx_gap = rx_gap - 1;
      end
      rsp_ch.ready <= (rx_gap == 0) && (hold_left == 0);
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc == LIMIT) begin
      $display("tb_pairing_key_table: FAIL");
      $finish;
    end
  end

  task automatic add_cmd(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                         input logic [ADDR_W-1:0] addr, input logic [KIND_W-1:0] kind,
                         input logic [TYPES_W-1:0] types, input logic [SLOT_W-1:0] slot,
                         input logic [BUSY_W-1:0] busy);
    key_cmd_t c;
    c.cmd = cmd;
    c.local_id = id;
    c.peer_address = addr;
    c.address_type = kind;
    c.type_bits = types;
    c.slot_index = slot;
    c.busy_mask = busy;
    c.drain = 1'b0;
    cmd_q.push_back(c);
  endtask

  function automatic void new_peer(int p);
    pool_id[p] = ID_W'($urandom);
    pool_addr[p] = ADDR_W'({$urandom, $urandom});
    pool_kind[p] = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 1));
  endfunction

  // mostly commands on a small pool of peers, so the table fills and entries get hit
  function automatic key_cmd_t random_cmd();
    key_cmd_t c;
    int p;
    int pick;
    p = int'($urandom_range(0, NPEERS - 1));
    if (p != 0 && $urandom_range(0, 39) == 0) new_peer(p);
    c.local_id = pool_id[p];
    c.peer_address = pool_addr[p];
    c.address_type = pool_kind[p];
    c.type_bits = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(1) << $urandom_range(0, 15);
    c.slot_index = SLOT_W'($urandom_range(0, 7));
    case ($urandom_range(0, 3))
      0: c.busy_mask = '0;
      1: c.busy_mask = '1;
      default: c.busy_mask = BUSY_W'($urandom);
    endcase
    c.drain = 1'b0;
    pick = int'($urandom_range(0, 99));
    if (pick < 25) c.cmd = CMD_GET;
    else if (pick < 40) c.cmd = CMD_GET_TYPE;
    else if (pick < 50) c.cmd = CMD_FIND_ADDR;
    else if (pick < 60) c.cmd = CMD_FIND_TYPE;
    else if (pick < 75) c.cmd = CMD_TOUCH;
    else if (pick < 83) c.cmd = CMD_CLEAR_SLOT;
    else if (pick < 91) c.cmd = CMD_ADD_TYPE;
    else begin
      // noise: every field random, unknown command included
      c.cmd = CMD_W'($urandom_range(0, 7));
      c.local_id = ID_W'($urandom);
      c.peer_address = ADDR_W'({$urandom, $urandom});
      c.address_type = KIND_W'($urandom);
      c.type_bits = TYPES_W'($urandom);
      c.busy_mask = BUSY_W'($urandom);
    end
    return c;
  endfunction

  // sampled on the falling edge so the driver's updates have settled
  task automatic wait_idle();
    while (cmd_q.size() != 0 || req_ch.valid || answer_q.size() != 0) @(negedge clk);
    repeat (PKT_ENTRIES + 6) @(posedge clk);
  endtask

  task automatic write_evict(input logic v);
    @(posedge clk);
    cfg_ch.evict_oldest_enable <= v;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    evict_on = v;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_phase(input int n, input int drain_at);
    key_cmd_t c;
    for (int k = 0; k < n; k++) begin
      c = random_cmd();
      if (k == drain_at) c.drain = 1'b1;
      cmd_q.push_back(c);
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] a1;
    logic [ADDR_W-1:0] a9;
    a1 = 48'h0000_0000_0001;
    a9 = '1;
    // entry in pool slot 0 has a zero address but a nonzero identity
    for (int p = 0; p < NPEERS; p++) new_peer(p);
    pool_id[0] = 8'h3C;
    pool_addr[0] = '0;
    pool_kind[0] = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    write_evict(1'b0);
    add_cmd(CMD_FIND_ADDR, 8'h00, a1, 8'h00, 16'h0000, 3'd0, 8'h00);
    // an all-zero request matches the first free entry
    add_cmd(CMD_FIND_ADDR, 8'h00, '0, 8'h00, 16'h0000, 3'd0, 8'h00);
    add_cmd(CMD_GET, 8'h00, a1, 8'h00, 16'h0000, 3'd0, 8'h00);
    add_cmd(CMD_GET, 8'h00, a1, 8'h00, 16'h0000, 3'd0, 8'h00);
    add_cmd(CMD_GET_TYPE, 8'h00, a1, 8'h00, 16'h0001, 3'd0, 8'h00);
    add_cmd(CMD_FIND_TYPE, 8'h00, a1, 8'h00, 16'h0001, 3'd0, 8'h00);
    add_cmd(CMD_FIND_TYPE, 8'h00, a1, 8'h00, 16'h8000, 3'd0, 8'h00);
    // touching the last touched entry changes nothing
    add_cmd(CMD_TOUCH, 8'h00, a1, 8'h00, 16'h0000, 3'd0, 8'h00);
    for (int k = 1; k < PKT_ENTRIES; k++)
      add_cmd(CMD_GET, 8'(k), {8'(k), 40'h5A_A55A_A55A}, 8'(k), 16'h0000, 3'd0, 8'h00);
    add_cmd(CMD_GET, 8'hFF, a9, 8'hFF, 16'hFFFF, 3'd7, 8'hFF);
    add_cmd(CMD_TOUCH, 8'h00, a1, 8'h00, 16'h0000, 3'd0, 8'h00);
    add_cmd(CMD_ADD_TYPE, 8'h00, '0, 8'h00, 16'hFFFF, 3'd7, 8'h00);
    add_cmd(CMD_CLEAR_SLOT, 8'h00, '0, 8'h00, 16'h0000, 3'd7, 8'h00);
    add_cmd(CMD_UNKNOWN, 8'hFF, a9, 8'hFF, 16'hFFFF, 3'd7, 8'hFF);
    add_cmd(CMD_TOUCH, 8'hFF, a9, 8'hFF, 16'h0000, 3'd0, 8'h00);
    add_cmd(CMD_GET_TYPE, 8'hFF, a9, 8'hFF, 16'h8000, 3'd0, 8'h00);
    wait_idle();

    write_evict(1'b1);
    // full table: evict, all busy, then all but entry 0 busy
    add_cmd(CMD_GET, 8'h80, 48'h8000_0000_0000, 8'h01, 16'h0000, 3'd0, 8'h00);
    add_cmd(CMD_GET, 8'h81, 48'h7FFF_FFFF_FFFF, 8'h01, 16'h0000, 3'd0, 8'hFF);
    add_cmd(CMD_GET, 8'h81, 48'h7FFF_FFFF_FFFF, 8'h01, 16'h0000, 3'd0, 8'hFE);
    random_phase(250, -1);
    wait_idle();

    // a stretch with no idling on either side
    tx_idle_on = 0;
    rx_idle_on = 0;
    write_evict(1'b0);
    random_phase(200, -1);
    wait_idle();

    tx_idle_on = 1;
    rx_idle_on = 1;
    write_evict(1'b1);
    random_phase(250, 120);
    wait_idle();

    if (n_bad == 0 && answer_q.size() == 0) begin
      $display("tb_pairing_key_table: PASS");
    end else begin
      $display("tb_pairing_key_table: FAIL");
    end
    $finish;
  end

endmodule
